>>> rtl/core/task_slice_scheduler_defines.svh
// Assertion macros used by the checker file.
`ifndef TASK_SLICE_SCHEDULER_DEFINES_SVH
`define TASK_SLICE_SCHEDULER_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define TSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property in the cycle after a trigger.
`define TSS_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

>>> rtl/core/tss_pkg.sv
package tss_pkg;

  localparam int unsigned TABLE_DEPTH   = 64;
  localparam int unsigned IDX_W         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W         = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OP_W          = 2;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned PRIO_W        = 8;
  localparam int unsigned BURST_W       = 16;
  localparam int unsigned TIME_W        = 23;
  localparam int unsigned TASK_IDX_W    = 6;
  localparam int unsigned STAT_W        = 30;
  localparam int unsigned FRAC_W        = 8;
  localparam int unsigned SUM_W         = TIME_W + CNT_W;
  localparam int unsigned DIVD_W        = SUM_W + FRAC_W;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam logic [BURST_W-1:0] QUANTUM_RESET = BURST_W'(5);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_NEXT  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_OK = 2'd0,
    KIND_SLICE   = 2'd1,
    KIND_STATS   = 2'd2,
    KIND_REJECT  = 2'd3
  } kind_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SJF  = 2'd0,
    MODE_RR   = 2'd1,
    MODE_PRR  = 2'd2,
    MODE_RSVD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 1'd0,
    REG_QUANTUM = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic               started;
    logic [TIME_W-1:0]  first_start;
    logic [TIME_W-1:0]  done_time;
  } entry_t;

  typedef struct packed {
    kind_e                 kind;
    logic [TASK_IDX_W-1:0] task_index;
    logic [TIME_W-1:0]     slice_start;
    logic [TIME_W-1:0]     slice_end;
    logic [STAT_W-1:0]     avg_wait;
    logic [STAT_W-1:0]     avg_resp;
  } result_t;

endpackage

>>> rtl/core/tss_if.sv
interface tss_in_if;
  logic                          valid;
  logic                          ready;
  logic [tss_pkg::OP_W-1:0]      operation;
  logic [tss_pkg::PRIO_W-1:0]    task_priority;
  logic [tss_pkg::BURST_W-1:0]   burst_length;

  modport source (output valid, operation, task_priority, burst_length, input ready);
  modport sink (input valid, operation, task_priority, burst_length, output ready);
endinterface

interface tss_out_if;
  logic                            valid;
  logic                            ready;
  logic [tss_pkg::KIND_W-1:0]      result_kind;
  logic [tss_pkg::TASK_IDX_W-1:0]  task_index;
  logic [tss_pkg::TIME_W-1:0]      slice_start;
  logic [tss_pkg::TIME_W-1:0]      slice_end;
  logic [tss_pkg::STAT_W-1:0]      avg_wait_fixed;
  logic [tss_pkg::STAT_W-1:0]      avg_response_fixed;

  modport source (output valid, result_kind, task_index, slice_start, slice_end,
                  avg_wait_fixed, avg_response_fixed, input ready);
  modport sink (input valid, result_kind, task_index, slice_start, slice_end,
                avg_wait_fixed, avg_response_fixed, output ready);
endinterface

>>> rtl/core/task_slice_scheduler.sv
// Task slice scheduler. Operation 0 loads a task (priority, burst) into the next free slot of a
// 64-entry table, 1 returns the next execution slice under the configured mode (shortest job
// first, round robin, priority round robin) or, once every task is done, the average waiting and
// response times with 8 fraction bits, 2 clears table and time; 3 is taken with no result. A
// load or clear result is registered and passed to the output register from the response
// state; a slice or stats request first scans the loaded tasks, one table read per cycle from
// the table memory, and a stats request then runs the bit-serial divider. The input is held
// off until the result is issued. The next item is taken while a result still waits at the
// output.
module task_slice_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tss_in_if.sink                         in_i,
  tss_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tss_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tss_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tss_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SCAN      = 6'b000010,
    ST_UPDATE    = 6'b000100,
    ST_DIV_START = 6'b001000,
    ST_DIV       = 6'b010000,
    ST_RESP      = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  mode_e              mode_q, mode_d;
  logic [BURST_W-1:0] quantum_q, quantum_d;
  logic [CNT_W-1:0]   loaded_q, loaded_d;
  logic [CNT_W-1:0]   unfin_q, unfin_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [IDX_W-1:0]   rr_q, rr_d;
  logic               stats_q, stats_d;
  logic [CNT_W-1:0]   issue_q, issue_d;
  logic [IDX_W-1:0]   addr_q, addr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic               found_q, found_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;
  entry_t             best_q, best_d;
  logic [SUM_W-1:0]   wsum_q, wsum_d;
  logic [SUM_W-1:0]   rsum_q, rsum_d;
  result_t            res_q, res_d;
  logic               out_vld_q, out_vld_d;
  result_t            out_res_q, out_res_d;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd_entry;
  logic [$bits(entry_t)-1:0] ram_rdata;

  logic               div_start, div_done;
  logic [DIVD_W-1:0]  quot_w, quot_r;

  entry_t             upd;
  logic [BURST_W-1:0] quant, slice;
  logic [TIME_W-1:0]  new_now;
  logic               take;

  tss_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tss_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .dividend_a_i ({wsum_q, FRAC_W'(0)} + DIVD_W'(loaded_q >> 1)),
    .dividend_b_i ({rsum_q, FRAC_W'(0)} + DIVD_W'(loaded_q >> 1)),
    .divisor_i    (loaded_q),
    .done_o       (div_done),
    .quot_a_o     (quot_w),
    .quot_b_o     (quot_r)
  );

  assign rd_entry = entry_t'(ram_rdata);

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    quantum_d  = quantum_q;
    loaded_d   = loaded_q;
    unfin_d    = unfin_q;
    now_d      = now_q;
    rr_d       = rr_q;
    stats_d    = stats_q;
    issue_d    = issue_q;
    addr_d     = addr_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    wsum_d     = wsum_q;
    rsum_d     = rsum_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q;
    out_res_d  = out_res_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = best_idx_q;
    ram_raddr  = addr_q;
    ram_wdata  = best_q;
    div_start  = 1'b0;
    in_i.ready = (state_q == ST_IDLE);
    take       = 1'b0;

    quant   = (quantum_q == '0) ? BURST_W'(1) : quantum_q;
    slice   = best_q.remaining;
    if ((mode_q == MODE_RR || mode_q == MODE_PRR) && best_q.remaining > quant) begin
      slice = quant;
    end
    new_now = now_q + TIME_W'(slice);
    upd     = best_q;
    if (!best_q.started) begin
      upd.started     = 1'b1;
      upd.first_start = now_q;
    end
    upd.remaining = best_q.remaining - slice;
    if (upd.remaining == '0) begin
      upd.done_time = new_now;
    end

    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_d    = mode_e'(cfg_wdata_i[MODE_W-1:0]);
        REG_QUANTUM: quantum_d = cfg_wdata_i[BURST_W-1:0];
      endcase
    end

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          res_d = '0;
          unique case (op_e'(in_i.operation))
            OP_LOAD: begin
              if (loaded_q == CNT_W'(TABLE_DEPTH) || in_i.burst_length == '0) begin
                res_d.kind = KIND_REJECT;
              end else begin
                ram_we                = 1'b1;
                ram_waddr             = IDX_W'(loaded_q);
                ram_wdata             = '0;
                ram_wdata.prio        = in_i.task_priority;
                ram_wdata.burst       = in_i.burst_length;
                ram_wdata.remaining   = in_i.burst_length;
                loaded_d              = loaded_q + 1'b1;
                unfin_d               = unfin_q + 1'b1;
                res_d.kind            = KIND_LOAD_OK;
                res_d.task_index      = TASK_IDX_W'(loaded_q);
              end
              state_d = ST_RESP;
            end
            OP_CLEAR: begin
              loaded_d   = '0;
              unfin_d    = '0;
              now_d      = '0;
              rr_d       = '0;
              res_d.kind = KIND_REJECT;
              state_d    = ST_RESP;
            end
            OP_NEXT: begin
              stats_d = (unfin_q == '0);
              issue_d = '0;
              addr_d  = (unfin_q != '0 && mode_q == MODE_RR) ? rr_q : '0;
              found_d = 1'b0;
              wsum_d  = '0;
              rsum_d  = '0;
              state_d = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_q != loaded_q) begin
          ram_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = addr_q;
          issue_d  = issue_q + 1'b1;
          addr_d   = (CNT_W'(addr_q) + 1'b1 == loaded_q) ? '0 : addr_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (stats_q) begin
            wsum_d = wsum_q + SUM_W'(rd_entry.done_time - TIME_W'(rd_entry.burst));
            rsum_d = rsum_q + SUM_W'(rd_entry.first_start);
          end else if (rd_entry.remaining != '0) begin
            if (!found_q) begin
              take = 1'b1;
            end else if (mode_q == MODE_PRR) begin
              take = rd_entry.prio < best_q.prio;
            end else if (mode_q != MODE_RR) begin
              take = rd_entry.burst < best_q.burst;
            end
            if (take) begin
              found_d    = 1'b1;
              best_idx_d = rd_idx_q;
              best_d     = rd_entry;
            end
          end
        end
        if (issue_q == loaded_q && !rd_vld_q) begin
          state_d = stats_q ? ST_DIV_START : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        ram_we            = 1'b1;
        ram_wdata         = upd;
        now_d             = new_now;
        res_d             = '0;
        res_d.kind        = KIND_SLICE;
        res_d.task_index  = TASK_IDX_W'(best_idx_q);
        res_d.slice_start = now_q;
        res_d.slice_end   = new_now;
        if (upd.remaining == '0) begin
          unfin_d = unfin_q - 1'b1;
        end
        if (mode_q == MODE_RR) begin
          rr_d = (CNT_W'(best_idx_q) + 1'b1 == loaded_q) ? '0 : best_idx_q + 1'b1;
        end
        state_d = ST_RESP;
      end
      ST_DIV_START: begin
        res_d      = '0;
        res_d.kind = KIND_STATS;
        if (loaded_q == '0) begin
          state_d = ST_RESP;
        end else begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_d.avg_wait = (|quot_w[DIVD_W-1:STAT_W]) ? '1 : quot_w[STAT_W-1:0];
          res_d.avg_resp = (|quot_r[DIVD_W-1:STAT_W]) ? '1 : quot_r[STAT_W-1:0];
          state_d        = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_res_d = res_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      mode_q    <= MODE_SJF;
      quantum_q <= QUANTUM_RESET;
      loaded_q  <= '0;
      unfin_q   <= '0;
      now_q     <= '0;
      rr_q      <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      quantum_q <= quantum_d;
      loaded_q  <= loaded_d;
      unfin_q   <= unfin_d;
      now_q     <= now_d;
      rr_q      <= rr_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    stats_q    <= stats_d;
    issue_q    <= issue_d;
    addr_q     <= addr_d;
    rd_idx_q   <= rd_idx_d;
    found_q    <= found_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    wsum_q     <= wsum_d;
    rsum_q     <= rsum_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.result_kind        = out_res_q.kind;
  assign out_o.task_index         = out_res_q.task_index;
  assign out_o.slice_start        = out_res_q.slice_start;
  assign out_o.slice_end          = out_res_q.slice_end;
  assign out_o.avg_wait_fixed     = out_res_q.avg_wait;
  assign out_o.avg_response_fixed = out_res_q.avg_resp;
endmodule

>>> rtl/core/tss_ram.sv
module tss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

>>> rtl/core/tss_div.sv
module tss_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tss_pkg::DIVD_W-1:0] dividend_a_i,
  input  logic [tss_pkg::DIVD_W-1:0] dividend_b_i,
  input  logic [tss_pkg::CNT_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [tss_pkg::DIVD_W-1:0] quot_a_o,
  output logic [tss_pkg::DIVD_W-1:0] quot_b_o
);
  import tss_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVD_W + 1);

  logic [1:0][DIVD_W-1:0] quot_q, quot_d;
  logic [1:0][CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]       dsr_q, dsr_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic                   run_q, run_d;
  logic                   done_q, done_d;
  logic [1:0][CNT_W:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    step_d = step_q;
    run_d  = run_q;
    done_d = 1'b0;
    for (int l = 0; l < 2; l++) begin
      trial[l] = {rem_q[l], quot_q[l][DIVD_W-1]};
    end
    if (start_i) begin
      quot_d = {dividend_b_i, dividend_a_i};
      rem_d  = '0;
      dsr_d  = divisor_i;
      step_d = '0;
      run_d  = 1'b1;
    end else if (run_q) begin
      for (int l = 0; l < 2; l++) begin
        if (trial[l] >= {1'b0, dsr_q}) begin
          rem_d[l]  = CNT_W'(trial[l] - {1'b0, dsr_q});
          quot_d[l] = {quot_q[l][DIVD_W-2:0], 1'b1};
        end else begin
          rem_d[l]  = trial[l][CNT_W-1:0];
          quot_d[l] = {quot_q[l][DIVD_W-2:0], 1'b0};
        end
      end
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIVD_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o   = done_q;
  assign quot_a_o = quot_q[0];
  assign quot_b_o = quot_q[1];
endmodule

>>> rtl/core/tss_checker.sv
`include "task_slice_scheduler_defines.svh"

module tss_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [tss_pkg::KIND_W-1:0]     result_kind_i,
  input logic [tss_pkg::TASK_IDX_W-1:0] task_index_i,
  input logic [tss_pkg::TIME_W-1:0]     slice_start_i,
  input logic [tss_pkg::TIME_W-1:0]     slice_end_i,
  input logic [tss_pkg::STAT_W-1:0]     avg_wait_i,
  input logic [tss_pkg::STAT_W-1:0]     avg_resp_i
);
  import tss_pkg::*;

  `TSS_ASSERT_NEXT(a_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(result_kind_i) && $stable(slice_end_i), "stalled transfer changed")
  `TSS_ASSERT(a_slice_len, !(out_valid_i && result_kind_i == KIND_SLICE) || slice_end_i != slice_start_i, "empty slice")
  `TSS_ASSERT(a_load_clean, !(out_valid_i && result_kind_i == KIND_LOAD_OK) || (slice_start_i == '0 && slice_end_i == '0 && avg_wait_i == '0 && avg_resp_i == '0), "load result carries data")
  `TSS_ASSERT(a_stats_clean, !(out_valid_i && result_kind_i == KIND_STATS) || (task_index_i == '0 && slice_start_i == '0 && slice_end_i == '0), "stats result carries slice")
endmodule

bind task_slice_scheduler tss_checker u_tss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_kind_i (out_o.result_kind),
  .task_index_i  (out_o.task_index),
  .slice_start_i (out_o.slice_start),
  .slice_end_i   (out_o.slice_end),
  .avg_wait_i    (out_o.avg_wait_fixed),
  .avg_resp_i    (out_o.avg_response_fixed)
);
